>>> src/assert_macros.svh
// Assertion macros shared by the presence set occupancy checker RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define PSOC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define PSOC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/psoc_pkg.sv
// Package for the presence set occupancy checker: item kinds, status codes,
// controller states and the structs passed along the slot cell chain. No dependencies.
`timescale 1ns / 1ps

package psoc_pkg;

    // Field widths fixed by the stream format.
    localparam int KIND_W   = 2;
    localparam int MKEY_W   = 16;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        K_ENTER = 2'd0,
        K_LEAVE = 2'd1,
        K_END   = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Lookup token that walks from cell to cell, one cell per cycle.
    typedef struct packed {
        logic active;
        logic hit;
        logic free_found;
    } t_scan;

    // Table update broadcast to all cells when an item commits.
    typedef struct packed {
        logic write;
        logic clear;
        logic clear_all;
    } t_cmd;

endpackage

>>> src/psoc_cell.sv
// One slot of the presence table: a key register, its valid bit and one
// stage of the lookup token chain. Depends on psoc_pkg.
`timescale 1ns / 1ps

module psoc_cell #(
    parameter int IDX_W    = 4,
    parameter int KEY_BITS = 16,
    parameter int CELL_IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  psoc_pkg::t_scan         i_scan,
    input  logic [IDX_W-1:0]        i_hit_idx,
    input  logic [IDX_W-1:0]        i_free_idx,
    input  logic [KEY_BITS-1:0]     i_key,
    output psoc_pkg::t_scan         o_scan,
    output logic [IDX_W-1:0]        o_hit_idx,
    output logic [IDX_W-1:0]        o_free_idx,
    input  psoc_pkg::t_cmd          i_cmd,
    input  logic [IDX_W-1:0]        i_cmd_idx,
    input  logic [KEY_BITS-1:0]     i_cmd_key,
    output logic                    o_valid
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    psoc_pkg::t_scan     r_scan;
    psoc_pkg::t_scan     n_scan;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [IDX_W-1:0]    n_hit_idx;
    logic [IDX_W-1:0]    r_free_idx;
    logic [IDX_W-1:0]    n_free_idx;
    logic                sel;

    assign sel = (i_cmd_idx == MY_IDX);

    // Fold this slot into the token: first match and lowest free slot.
    always_comb begin
        n_scan     = i_scan;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        if (i_scan.active) begin
            if (r_valid && (r_key == i_key) && !i_scan.hit) begin
                n_scan.hit = 1'b1;
                n_hit_idx  = MY_IDX;
            end
            if (!r_valid && !i_scan.free_found) begin
                n_scan.free_found = 1'b1;
                n_free_idx        = MY_IDX;
            end
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
    end

    // Slot contents follow the broadcast update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clear_all) begin
            r_valid <= 1'b0;
        end else if (i_cmd.write && sel) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clear && sel) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && sel) begin
            r_key <= i_cmd_key;
        end
    end

    assign o_scan     = r_scan;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;
    assign o_valid    = r_valid;

endmodule

>>> src/presence_set_occupancy_checker.sv
// Top level of the presence set occupancy checker: stream ports, item
// controller, result register and the row of psoc_cell slots. Depends on psoc_pkg.
//
//  Channel  | Dir | tdata (low bit first)                          | tuser
//  s_axis   | in  | member_key[15:0]                               | kind[1:0]
//  m_axis   | out | occupancy[4:0], peak_occupancy[9:5],           | status[2:0]
//           |     | case_failed[10], zero[15:11]                   |
//
// An enter or leave item has its result loaded once a lookup token has walked the slot
// row, one cell per cycle, and the item then commits.
// End items, unused kinds and items after an error skip the lookup and go straight to commit.
// One item is in work at a time; s_axis_tready is high only while idle, which
// it is again from the clock edge that loads the result.
// A result waits in the output register until taken; commit stalls meanwhile.
// Reset is synchronous, active low, and empties the table at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module presence_set_occupancy_checker #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [psoc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // member_key
    input  logic [psoc_pkg::KIND_W-1:0]         s_axis_tuser,  // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [psoc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // occupancy, peak, case_failed
    output logic [psoc_pkg::STATUS_W-1:0]       m_axis_tuser   // status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    psoc_pkg::t_state  r_state;
    psoc_pkg::t_state  n_state;
    psoc_pkg::t_kind   r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic              r_start;
    logic              in_xfer;
    logic              needs_scan;
    logic              commit;

    // Lookup result latched from the end of the chain.
    logic              r_hit;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [IDX_W-1:0]  r_free_idx;

    // Case state.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_peak;
    logic [CNT_W-1:0]  n_peak;
    logic              r_err;
    logic              n_err;

    // Result register.
    logic                  r_ovalid;
    psoc_pkg::t_status     r_ostatus;
    psoc_pkg::t_status     n_status;
    logic [psoc_pkg::OCC_W-1:0] r_oocc;
    logic [psoc_pkg::OCC_W-1:0] r_opeak;
    logic                  r_ofail;
    logic [psoc_pkg::OCC_W-1:0] rep_occ;
    logic [psoc_pkg::OCC_W-1:0] rep_peak;
    logic                  rep_fail;

    // Update broadcast.
    psoc_pkg::t_cmd    dec_cmd;
    psoc_pkg::t_cmd    cmd;
    logic [IDX_W-1:0]  cmd_idx;

    // Cell chain wiring.
    psoc_pkg::t_scan   scan_c     [0:CAPACITY];
    logic [IDX_W-1:0]  hit_idx_c  [0:CAPACITY];
    logic [IDX_W-1:0]  free_idx_c [0:CAPACITY];
    logic [CAPACITY-1:0] valid_vec;

    assign s_axis_tready = (r_state == psoc_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign needs_scan    = !r_err && ((s_axis_tuser == psoc_pkg::K_ENTER) ||
                                      (s_axis_tuser == psoc_pkg::K_LEAVE));
    assign commit        = (r_state == psoc_pkg::S_COMMIT) && (!r_ovalid || m_axis_tready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            psoc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = needs_scan ? psoc_pkg::S_SCAN : psoc_pkg::S_COMMIT;
                end
            end
            psoc_pkg::S_SCAN: begin
                if (scan_c[CAPACITY].active) begin
                    n_state = psoc_pkg::S_COMMIT;
                end
            end
            psoc_pkg::S_COMMIT: begin
                if (commit) begin
                    n_state = psoc_pkg::S_IDLE;
                end
            end
            default: n_state = psoc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psoc_pkg::S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= in_xfer && needs_scan;
        end
    end

    // Capture the accepted item.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= psoc_pkg::t_kind'(s_axis_tuser);
            r_key  <= KEY_BITS'(s_axis_tdata);
        end
    end

    // Latch the lookup result as the token leaves the last cell.
    always_ff @(posedge i_clk) begin
        if (r_state == psoc_pkg::S_SCAN && scan_c[CAPACITY].active) begin
            r_hit        <= scan_c[CAPACITY].hit;
            r_free_found <= scan_c[CAPACITY].free_found;
            r_hit_idx    <= hit_idx_c[CAPACITY];
            r_free_idx   <= free_idx_c[CAPACITY];
        end
    end

    // Item decision: status, table update and new case state.
    always_comb begin
        n_count  = r_count;
        n_peak   = r_peak;
        n_err    = r_err;
        n_status = psoc_pkg::ST_OK;
        dec_cmd  = '0;
        cmd_idx  = r_free_idx;
        case (r_kind)
            psoc_pkg::K_END: begin
                dec_cmd.clear_all = 1'b1;
                n_count = '0;
                n_peak  = '0;
                n_err   = 1'b0;
            end
            psoc_pkg::K_ENTER: begin
                if (r_err) begin
                    n_status = psoc_pkg::ST_IGNORED;
                end else if (r_hit) begin
                    n_status = psoc_pkg::ST_DUP;
                    n_err    = 1'b1;
                end else if (!r_free_found) begin
                    n_status = psoc_pkg::ST_FULL;
                    n_err    = 1'b1;
                end else begin
                    dec_cmd.write = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                    if (n_count > r_peak) begin
                        n_peak = n_count;
                    end
                end
            end
            psoc_pkg::K_LEAVE: begin
                if (r_err) begin
                    n_status = psoc_pkg::ST_IGNORED;
                end else if (!r_hit) begin
                    n_status = psoc_pkg::ST_ABSENT;
                    n_err    = 1'b1;
                end else begin
                    dec_cmd.clear = 1'b1;
                    cmd_idx = r_hit_idx;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            default: begin
                n_status = psoc_pkg::ST_OK;
            end
        endcase
    end

    // An end item reports the closing case's peak and error flag, with occupancy zero, before it is cleared.
    always_comb begin
        if (r_kind == psoc_pkg::K_END) begin
            rep_occ  = '0;
            rep_peak = psoc_pkg::OCC_W'(r_peak);
            rep_fail = r_err;
        end else begin
            rep_occ  = psoc_pkg::OCC_W'(n_count);
            rep_peak = psoc_pkg::OCC_W'(n_peak);
            rep_fail = n_err;
        end
    end

    assign cmd = commit ? dec_cmd : '0;

    // Case state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= '0;
            r_err   <= 1'b0;
        end else if (commit) begin
            r_count <= n_count;
            r_peak  <= n_peak;
            r_err   <= n_err;
        end
    end

    // Result register: filled on commit, emptied by an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (commit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_ostatus <= n_status;
            r_oocc    <= rep_occ;
            r_opeak   <= rep_peak;
            r_ofail   <= rep_fail;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {5'd0, r_ofail, r_opeak, r_oocc};

    // Token injection at the head of the row.
    assign scan_c[0]     = '{active: r_start, hit: 1'b0, free_found: 1'b0};
    assign hit_idx_c[0]  = '0;
    assign free_idx_c[0] = '0;

    // Row of slot cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        psoc_cell #(
            .IDX_W    (IDX_W),
            .KEY_BITS (KEY_BITS),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_scan     (scan_c[g]),
            .i_hit_idx  (hit_idx_c[g]),
            .i_free_idx (free_idx_c[g]),
            .i_key      (r_key),
            .o_scan     (scan_c[g+1]),
            .o_hit_idx  (hit_idx_c[g+1]),
            .o_free_idx (free_idx_c[g+1]),
            .i_cmd      (cmd),
            .i_cmd_idx  (cmd_idx),
            .i_cmd_key  (r_key),
            .o_valid    (valid_vec[g])
        );
    end

    // Checks on the controller and the table.
    `PSOC_ASSERT(a_count_matches_valid, i_clk, i_rst_n, ($countones(valid_vec) == r_count), "occupancy count differs from the number of valid slots")
    `PSOC_ASSERT(a_peak_covers_count, i_clk, i_rst_n, (r_peak >= r_count), "peak occupancy fell below current occupancy")
    `PSOC_ASSERT(a_end_clears, i_clk, i_rst_n, (commit && r_kind == psoc_pkg::K_END) |=> (valid_vec == '0 && !r_err), "end of case left slots or the error flag set")
    `PSOC_NEVER(a_token_only_in_scan, i_clk, i_rst_n, (scan_c[CAPACITY].active && r_state != psoc_pkg::S_SCAN), "lookup token left the row outside the scan state")

endmodule
